FILE: src/brfbp_pkg.sv
// ----------------------------------------------------------------------------
// brfbp_pkg
// Types and codes shared by the ring byte FIFO front end, command queue and
// execution back end.
// ----------------------------------------------------------------------------
package brfbp_pkg;

    localparam int CW = 11;   // capacity and fill width
    localparam int DW = 8;    // data byte
    localparam int KW = 2;    // kind code
    localparam int NW = 7;    // count field
    localparam int OW = 10;   // peek offset
    localparam int SW = 3;    // status code

    localparam logic [CW-1:0] CAP_RESET = CW'(1024);
    localparam int MAX_RESULTS = 64;

    // kind codes of an input item
    localparam logic [KW-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KW-1:0] KIND_POP   = 2'd1;
    localparam logic [KW-1:0] KIND_PEEK  = 2'd2;
    localparam logic [KW-1:0] KIND_CLEAR = 2'd3;

    // result status codes
    localparam logic [SW-1:0] STAT_OK    = 3'd0;
    localparam logic [SW-1:0] STAT_EMPTY = 3'd1;
    localparam logic [SW-1:0] STAT_FULL  = 3'd2;
    localparam logic [SW-1:0] STAT_OVF_W = 3'd3;
    localparam logic [SW-1:0] STAT_UNF_R = 3'd4;
    localparam logic [SW-1:0] STAT_BAD   = 3'd5;

    // command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_MOD,
        BS_READ,
        BS_EMIT
    } t_bstate;

    typedef struct packed {
        logic [KW-1:0] kind;
        logic [DW-1:0] data_in;
        logic [NW-1:0] count;
        logic          first;
        logic [OW-1:0] offset;
    } t_in;

    typedef struct packed {
        logic [DW-1:0] data_out;
        logic [SW-1:0] status;
        logic [CW-1:0] fill;
        logic          last;
    } t_out;

    typedef struct packed {
        t_op           op;
        logic          bad;
        logic [DW-1:0] data;
        logic [NW-1:0] count;
        logic          first;
        logic [OW-1:0] offset;
    } t_cmd;

endpackage

FILE: src/brfbp_front.sv
// ----------------------------------------------------------------------------
// brfbp_front
// Accepts input items, decodes the kind and flags out-of-range counts, and
// holds the decoded command in one register stage toward the queue.
// ----------------------------------------------------------------------------
module brfbp_front #(
    parameter int MAX_BURST = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  brfbp_pkg::t_in    i_in_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_stall,
    output brfbp_pkg::t_cmd   o_cmd
);
    import brfbp_pkg::*;

    localparam int LIMIT = (MAX_BURST < MAX_RESULTS) ? MAX_BURST : MAX_RESULTS;
    localparam logic [NW:0] BURST_MAX = (NW+1)'(MAX_BURST);
    localparam logic [NW:0] READ_MAX  = (NW+1)'(LIMIT);

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        w_cmd;
    logic [NW:0] w_cnt;
    logic        w_accept;

    assign w_cnt      = {1'b0, i_in_item.count};
    assign o_in_stall = r_valid && i_cmd_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        w_cmd.data   = i_in_item.data_in;
        w_cmd.count  = i_in_item.count;
        w_cmd.first  = i_in_item.first;
        w_cmd.offset = i_in_item.offset;
        case (i_in_item.kind)
            KIND_PUSH: begin
                w_cmd.op  = OP_PUSH;
                w_cmd.bad = i_in_item.first && (w_cnt == '0 || w_cnt > BURST_MAX);
            end
            KIND_POP: begin
                w_cmd.op  = OP_POP;
                w_cmd.bad = w_cnt > READ_MAX;
            end
            KIND_PEEK: begin
                w_cmd.op  = OP_PEEK;
                w_cmd.bad = w_cnt == '0 || w_cnt > READ_MAX;
            end
            default: begin
                w_cmd.op  = OP_CLEAR;
                w_cmd.bad = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_cmd_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: src/brfbp_queue.sv
// ----------------------------------------------------------------------------
// brfbp_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module brfbp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_stall,
    input  brfbp_pkg::t_cmd   i_push_cmd,
    output logic              o_pop_valid,
    input  logic              i_pop_take,
    output brfbp_pkg::t_cmd   o_pop_cmd
);
    import brfbp_pkg::*;

    t_cmd            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_push_stall = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_cmd    = r_slot[r_rd];
    assign w_push       = i_push_valid && !o_push_stall;
    assign w_pop        = i_pop_take && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr] <= i_push_cmd;
        end
    end

endmodule

FILE: src/brfbp_back.sv
// ----------------------------------------------------------------------------
// brfbp_back
// Executes commands against the ring store: push bursts, counted pops, peeks
// and clears. Owns the capacity register, ring pointers and result register.
// Slots outside the occupied span read as zero by ring distance, so popped
// and cleared slots are never rewritten.
// ----------------------------------------------------------------------------
module brfbp_back #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [brfbp_pkg::CW-1:0] i_cfg_data,
    input  logic                     i_cmd_valid,
    input  brfbp_pkg::t_cmd          i_cmd,
    output logic                     o_cmd_take,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output brfbp_pkg::t_out          o_out_item
);
    import brfbp_pkg::*;

    localparam int MEM_D = (DEPTH < 2047) ? DEPTH : 2047;
    localparam int IW    = $clog2(MEM_D);
    localparam int STW   = $clog2(OW);
    localparam logic [CW-1:0] CAP_MAX = CW'(MEM_D);

    function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v,
                                               input logic [CW-1:0] c);
        logic [CW-1:0] s;
        s = v + CW'(1);
        return (s == c) ? '0 : s;
    endfunction

    logic [DW-1:0]  r_mem [MEM_D];
    logic [DW-1:0]  r_rdata;

    t_bstate        r_state, n_state;
    logic [CW-1:0]  r_cap,   n_cap;
    logic [IW-1:0]  r_head,  n_head;
    logic [IW-1:0]  r_tail,  n_tail;
    logic [CW-1:0]  r_fill,  n_fill;
    logic           r_drop,  n_drop;
    logic [NW-1:0]  r_left,  n_left;
    logic [NW-1:0]  r_cnt,   n_cnt;
    logic [CW-1:0]  r_dist,  n_dist;
    logic           r_pop,   n_pop;
    logic           r_hit;
    logic [CW-1:0]  r_rem,   n_rem;
    logic [OW-1:0]  r_off,   n_off;
    logic [STW-1:0] r_step,  n_step;
    logic           r_out_valid, n_out_valid;
    t_out           r_out,   n_out;

    logic [CW-1:0]  w_cap;
    logic           w_full;
    logic           w_empty;
    logic [SW-1:0]  w_mode;
    logic [CW-1:0]  w_room;
    logic [CW-1:0]  w_cnt;
    logic [CW:0]    w_sum;
    logic [CW:0]    w_pos;
    logic [IW-1:0]  w_rd_addr;
    logic [CW:0]    w_trial;
    logic [CW:0]    w_rem_nx;
    logic           w_load_ok;
    logic           w_multi;
    logic           w_we;
    logic [CW-1:0]  w_head_nx;
    logic [CW-1:0]  w_tail_nx;

    // effective capacity, clamped to 1..store depth
    assign w_cap = (r_cap == '0) ? CW'(1) : ((r_cap > CAP_MAX) ? CAP_MAX : r_cap);
    assign w_full  = r_fill >= w_cap;
    assign w_empty = r_fill == '0;
    assign w_mode  = w_empty ? STAT_EMPTY : (w_full ? STAT_FULL : STAT_OK);
    assign w_room  = w_cap - r_fill;
    assign w_cnt   = CW'(i_cmd.count);

    // read slot: head plus ring distance, wrapped once
    assign w_sum     = {1'b0, CW'(r_head)} + {1'b0, r_dist};
    assign w_pos     = (w_sum >= {1'b0, w_cap}) ? w_sum - {1'b0, w_cap} : w_sum;
    assign w_rd_addr = w_pos[IW-1:0];

    // one step of offset modulo capacity
    assign w_trial  = {r_rem, r_off[OW-1]};
    assign w_rem_nx = (w_trial >= {1'b0, w_cap}) ? w_trial - {1'b0, w_cap} : w_trial;

    assign w_head_nx = wrap_inc(CW'(r_head), w_cap);
    assign w_tail_nx = wrap_inc(CW'(r_tail), w_cap);

    assign w_load_ok = !r_out_valid || !i_out_stall;
    assign w_multi   = (i_cmd.op == OP_POP && !i_cmd.bad && !w_empty &&
                        w_cnt != '0 && w_cnt <= r_fill) ||
                       (i_cmd.op == OP_PEEK && !i_cmd.bad);
    assign o_cmd_take = (r_state == BS_IDLE) && i_cmd_valid && !i_cfg_we &&
                        (w_multi || w_load_ok);

    // next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = BS_IDLE;
        end else begin
            case (r_state)
                BS_IDLE: begin
                    if (o_cmd_take && w_multi) begin
                        n_state = (i_cmd.op == OP_PEEK) ? BS_MOD : BS_READ;
                    end
                end
                BS_MOD: begin
                    if (r_step == STW'(OW-1)) begin
                        n_state = BS_READ;
                    end
                end
                BS_READ: begin
                    n_state = BS_EMIT;
                end
                BS_EMIT: begin
                    if (w_load_ok) begin
                        n_state = (r_cnt == NW'(1)) ? BS_IDLE : BS_READ;
                    end
                end
                default: begin
                    n_state = BS_IDLE;
                end
            endcase
        end
    end

    // datapath and results
    always_comb begin
        n_cap       = r_cap;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_drop      = r_drop;
        n_left      = r_left;
        n_cnt       = r_cnt;
        n_dist      = r_dist;
        n_pop       = r_pop;
        n_rem       = r_rem;
        n_off       = r_off;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;

        if (i_cfg_we) begin
            // a capacity write empties the FIFO
            n_cap  = i_cfg_data;
            n_head = '0;
            n_tail = '0;
            n_fill = '0;
            n_drop = 1'b0;
            n_left = '0;
        end else begin
            case (r_state)
                BS_IDLE: begin
                    if (o_cmd_take && w_multi) begin
                        n_cnt  = i_cmd.count;
                        n_dist = '0;
                        n_pop  = i_cmd.op == OP_POP;
                        n_rem  = '0;
                        n_off  = i_cmd.offset;
                        n_step = '0;
                    end else if (o_cmd_take) begin
                        n_out.data_out = '0;
                        n_out.status   = STAT_OK;
                        n_out.last     = 1'b1;
                        case (i_cmd.op)
                            OP_PUSH: begin
                                if (i_cmd.first) begin
                                    n_drop = 1'b1;
                                    n_left = '0;
                                    if (i_cmd.bad) begin
                                        n_out.status = STAT_BAD;
                                    end else if (w_full) begin
                                        n_out.status = STAT_FULL;
                                    end else if (w_cnt > w_room) begin
                                        n_out.status = STAT_OVF_W;
                                    end else begin
                                        n_drop = 1'b0;
                                        n_left = i_cmd.count - NW'(1);
                                        w_we   = 1'b1;
                                    end
                                end else if (r_drop) begin
                                    n_out.status = STAT_OVF_W;
                                end else if (r_left == '0) begin
                                    n_out.status = STAT_BAD;
                                end else if (w_full) begin
                                    n_drop       = 1'b1;
                                    n_left       = '0;
                                    n_out.status = STAT_FULL;
                                end else begin
                                    n_left = r_left - NW'(1);
                                    w_we   = 1'b1;
                                end
                                if (w_we) begin
                                    n_tail = w_tail_nx[IW-1:0];
                                    n_fill = r_fill + CW'(1);
                                    n_out.status = (n_fill >= w_cap) ? STAT_FULL : STAT_OK;
                                end
                            end
                            OP_POP: begin
                                if (i_cmd.bad) begin
                                    n_out.status = STAT_BAD;
                                end else if (w_empty) begin
                                    n_out.status = STAT_EMPTY;
                                end else if (w_cnt == '0) begin
                                    n_out.status = w_mode;
                                end else begin
                                    n_out.status = STAT_UNF_R;
                                end
                            end
                            OP_PEEK: begin
                                n_out.status = STAT_BAD;
                            end
                            default: begin
                                n_head = '0;
                                n_tail = '0;
                                n_fill = '0;
                                n_drop = 1'b0;
                                n_left = '0;
                            end
                        endcase
                        n_out.fill  = n_fill;
                        n_out_valid = 1'b1;
                    end
                end
                BS_MOD: begin
                    n_rem  = w_rem_nx[CW-1:0];
                    n_off  = {r_off[OW-2:0], 1'b0};
                    n_step = r_step + STW'(1);
                    if (r_step == STW'(OW-1)) begin
                        n_dist = w_rem_nx[CW-1:0];
                    end
                end
                BS_READ: begin
                end
                BS_EMIT: begin
                    if (w_load_ok) begin
                        n_out.data_out = r_hit ? r_rdata : '0;
                        n_out.last     = r_cnt == NW'(1);
                        n_out.status   = STAT_OK;
                        if (r_pop) begin
                            n_head = w_head_nx[IW-1:0];
                            n_fill = r_fill - CW'(1);
                            if (n_fill == '0) begin
                                n_out.status = STAT_EMPTY;
                            end
                        end else begin
                            n_dist = wrap_inc(r_dist, w_cap);
                        end
                        n_out.fill  = n_fill;
                        n_cnt       = r_cnt - NW'(1);
                        n_out_valid = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_cap       <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_left      <= '0;
            r_cnt       <= '0;
            r_dist      <= '0;
            r_pop       <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_left      <= n_left;
            r_cnt       <= n_cnt;
            r_dist      <= n_dist;
            r_pop       <= n_pop;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_off <= n_off;
        r_out <= n_out;
    end

    // ring store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_tail] <= i_cmd.data;
        end
        if (r_state == BS_READ) begin
            r_rdata <= r_mem[w_rd_addr];
            // pops always hit stored data; a peek hits only inside the fill
            r_hit   <= r_pop || (r_dist < r_fill);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: src/byte_ring_fifo_burst_peek_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_burst_peek_unit
// Circular byte FIFO with burst push, counted pop, offset peek and clear.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------
//  in      | input     | i_in_valid / o_in_stall   | i_in_item  (t_in)
//  out     | output    | o_out_valid / i_out_stall | o_out_item (t_out)
//  cfg     | input     | i_cfg_we                  | i_cfg_data (capacity)
//
// A push or clear, and any rejected request, is handled in the back end's idle
// state and gives one result. A pop or peek of N bytes is taken in the idle
// state, then each byte gets one store read and one result register load; a
// peek first reduces its offset modulo the capacity. Items pass a
// decode register and a two-entry queue first, so three more items are taken
// while the back end works.
// Reset (synchronous, active low) empties the FIFO at once, no sweep of the
// store. A stalled output holds the back end; the front fills until the queue
// is full.
// ----------------------------------------------------------------------------
module byte_ring_fifo_burst_peek_unit #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [brfbp_pkg::CW-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  brfbp_pkg::t_in           i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output brfbp_pkg::t_out          o_out_item
);
    import brfbp_pkg::*;

    logic fe_valid;
    logic fe_stall;
    t_cmd fe_cmd;
    logic q_valid;
    logic q_take;
    t_cmd q_cmd;

    brfbp_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_cmd_valid (fe_valid),
        .i_cmd_stall (fe_stall),
        .o_cmd       (fe_cmd)
    );

    brfbp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fe_valid),
        .o_push_stall (fe_stall),
        .i_push_cmd   (fe_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_take   (q_take),
        .o_pop_cmd    (q_cmd)
    );

    brfbp_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_take  (q_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
